/* rtl/core/dma_register_programming_sequencer_assert.svh */
// Assertion macros for the DMA register programming sequencer.
`ifndef DMA_REGISTER_PROGRAMMING_SEQUENCER_ASSERT_SVH
`define DMA_REGISTER_PROGRAMMING_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

`define DRPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define DRPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define DRPS_ASSERT(label, prop, msg)

`define DRPS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

/* rtl/core/dma_seq_pkg.sv */
// Types and codes of the DMA register programming sequencer.
package dma_seq_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] err_t;
  typedef logic [2:0] seq_state_t;

  localparam logic [7:0] CMD_ENABLE      = 8'h87;
  localparam logic [7:0] CMD_DISABLE     = 8'h83;
  localparam logic [7:0] CMD_FORCE_READY = 8'hB3;
  localparam logic [7:0] CMD_RESET       = 8'hC3;
  localparam logic [7:0] CMD_LOAD        = 8'hCF;

  localparam logic [7:0] WR0_FOLLOW_MASK = 8'h78;
  localparam logic [7:0] WR4_FOLLOW_MASK = 8'h1C;
  localparam logic [7:0] WR12_FOLLOW_BIT = 8'h40;

  localparam logic [1:0] SEL_WR4 = 2'd1;
  localparam logic [1:0] SEL_WR5 = 2'd2;
  localparam logic [1:0] SEL_WR6 = 2'd3;

  localparam kind_t KIND_NONE        = 2'd0;
  localparam kind_t KIND_MEM_TO_MEM  = 2'd1;
  localparam kind_t KIND_SEARCH      = 2'd2;
  localparam kind_t KIND_UNSUPPORTED = 2'd3;

  localparam err_t ERR_OK       = 2'd0;
  localparam err_t ERR_BAD_REG  = 2'd1;
  localparam err_t ERR_BAD_WR6  = 2'd2;

  localparam logic [1:0] MODE_SEARCH   = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

endpackage

/* rtl/core/dma_register_programming_sequencer.sv */
// Top level of the DMA register programming sequencer.
//
// Usage: one control byte per transaction enters on the input channel
// (in_valid, in_stall, control_byte). Every byte yields exactly one result
// transaction on the output channel (out_valid, out_stall and the result
// fields): the transfer classification on an enable command, the start
// addresses and length, an error code, the enable and force ready flags and
// whether follow-on bytes are still expected.
// Pipeline: a byte accepted into the input register is decoded from it, and
// its result is registered into the result register that drives the output.
// Throughput: one byte per cycle while out_stall does not hold a result; the
// programming state is read and written by the single decode stage between
// the input register and the result register.
// Reset (rst, synchronous): the sequencer returns to the base state and all
// programmed registers, counters and flags clear; both channels go empty.
// Stall: while out_stall holds a result, the decode stage holds the byte in
// the input register and in_stall rises once that register is full.
module dma_register_programming_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] control_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] transfer_kind,
  output logic [15:0] source_address,
  output logic [15:0] dest_address,
  output logic [15:0] transfer_length,
  output logic [1:0] error_code,
  output logic       dma_enabled,
  output logic       ready_forced,
  output logic       awaiting_operand
);

  localparam dma_seq_pkg::seq_state_t SEQ_BASE = 3'd0;
  localparam dma_seq_pkg::seq_state_t SEQ_WR0  = 3'd1;
  localparam dma_seq_pkg::seq_state_t SEQ_WR1  = 3'd2;
  localparam dma_seq_pkg::seq_state_t SEQ_WR2  = 3'd3;
  localparam dma_seq_pkg::seq_state_t SEQ_WR4  = 3'd4;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       proc_fire;
  logic       in_fire;

  dma_seq_pkg::seq_state_t sequence_state, sequence_state_next;
  logic [3:0]  wr0_pending, wr0_pending_next;
  logic [2:0]  wr4_pending, wr4_pending_next;
  logic [15:0] port_a_start, port_a_start_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] port_b_start, port_b_start_next;
  logic [15:0] port_a_counter, port_a_counter_next;
  logic [15:0] port_b_counter, port_b_counter_next;
  logic        direction_flag, direction_flag_next;
  logic [1:0]  transfer_mode, transfer_mode_next;
  logic        port_a_is_io, port_a_is_io_next;
  logic [1:0]  port_a_fixed, port_a_fixed_next;
  logic        port_b_is_io, port_b_is_io_next;
  logic [1:0]  port_b_fixed, port_b_fixed_next;
  logic [7:0]  port_a_timing, port_a_timing_next;
  logic [7:0]  port_b_timing, port_b_timing_next;
  logic [7:0]  interrupt_control, interrupt_control_next;
  logic [7:0]  wr5_value, wr5_value_next;
  logic        enable_flag, enable_flag_next;
  logic        force_ready_flag, force_ready_flag_next;

  dma_seq_pkg::kind_t kind_next;
  dma_seq_pkg::err_t  err_next;
  logic [15:0] src_next, dst_next, len_next;
  logic [15:0] advance;

  assign proc_fire = byte_valid && (!out_valid || !out_stall);
  assign in_stall  = byte_valid && !proc_fire;
  assign in_fire   = in_valid && !in_stall;
  assign advance   = block_length + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_fire) begin
      byte_valid <= 1'b1;
    end else if (proc_fire) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_q <= control_byte;
    end
  end

  always_comb begin
    sequence_state_next    = sequence_state;
    wr0_pending_next       = wr0_pending;
    wr4_pending_next       = wr4_pending;
    port_a_start_next      = port_a_start;
    block_length_next      = block_length;
    port_b_start_next      = port_b_start;
    port_a_counter_next    = port_a_counter;
    port_b_counter_next    = port_b_counter;
    direction_flag_next    = direction_flag;
    transfer_mode_next     = transfer_mode;
    port_a_is_io_next      = port_a_is_io;
    port_a_fixed_next      = port_a_fixed;
    port_b_is_io_next      = port_b_is_io;
    port_b_fixed_next      = port_b_fixed;
    port_a_timing_next     = port_a_timing;
    port_b_timing_next     = port_b_timing;
    interrupt_control_next = interrupt_control;
    wr5_value_next         = wr5_value;
    enable_flag_next       = enable_flag;
    force_ready_flag_next  = force_ready_flag;
    kind_next = dma_seq_pkg::KIND_NONE;
    err_next  = dma_seq_pkg::ERR_OK;
    src_next  = 16'd0;
    dst_next  = 16'd0;
    len_next  = 16'd0;

    unique case (sequence_state)
      SEQ_BASE: begin
        if (byte_q[7]) begin
          priority if (byte_q[1:0] == dma_seq_pkg::SEL_WR4) begin
            wr4_pending_next = 3'((byte_q & dma_seq_pkg::WR4_FOLLOW_MASK) >> 2);
            if (wr4_pending_next != 3'd0) begin
              sequence_state_next = SEQ_WR4;
            end
          end else if (byte_q[1:0] == dma_seq_pkg::SEL_WR5) begin
            wr5_value_next = byte_q;
          end else if (byte_q[1:0] == dma_seq_pkg::SEL_WR6) begin
            priority if (byte_q == dma_seq_pkg::CMD_DISABLE) begin
              enable_flag_next = 1'b0;
            end else if (byte_q == dma_seq_pkg::CMD_ENABLE) begin
              enable_flag_next = 1'b1;
              priority if (force_ready_flag && direction_flag &&
                           transfer_mode == dma_seq_pkg::MODE_TRANSFER && !port_a_is_io) begin
                kind_next = dma_seq_pkg::KIND_MEM_TO_MEM;
                src_next  = port_a_counter;
                dst_next  = port_b_counter;
                len_next  = block_length;
                port_a_counter_next = port_a_counter + advance;
                port_b_counter_next = port_b_counter + advance;
              end else if (!force_ready_flag && !direction_flag &&
                           transfer_mode == dma_seq_pkg::MODE_SEARCH && !port_a_is_io) begin
                kind_next = dma_seq_pkg::KIND_SEARCH;
                src_next  = port_a_counter;
                dst_next  = port_b_counter;
                len_next  = block_length;
              end else begin
                kind_next = dma_seq_pkg::KIND_UNSUPPORTED;
              end
            end else if (byte_q == dma_seq_pkg::CMD_FORCE_READY) begin
              force_ready_flag_next = 1'b1;
            end else if (byte_q == dma_seq_pkg::CMD_RESET) begin
              enable_flag_next      = 1'b0;
              force_ready_flag_next = 1'b0;
              port_a_timing_next    = 8'd0;
              port_b_timing_next    = 8'd0;
            end else if (byte_q == dma_seq_pkg::CMD_LOAD) begin
              port_a_counter_next   = port_a_start;
              port_b_counter_next   = port_b_start;
              force_ready_flag_next = 1'b0;
            end else begin
              err_next = dma_seq_pkg::ERR_BAD_WR6;
            end
          end else begin
            err_next = dma_seq_pkg::ERR_BAD_REG;
          end
        end else if (byte_q[1:0] != 2'd0) begin
          direction_flag_next = byte_q[2];
          transfer_mode_next  = byte_q[1:0];
          wr0_pending_next    = 4'((byte_q & dma_seq_pkg::WR0_FOLLOW_MASK) >> 3);
          if (wr0_pending_next != 4'd0) begin
            sequence_state_next = SEQ_WR0;
          end
        end else if (byte_q[2]) begin
          port_a_is_io_next = byte_q[3];
          port_a_fixed_next = byte_q[5:4];
          if ((byte_q & dma_seq_pkg::WR12_FOLLOW_BIT) != 8'd0) begin
            sequence_state_next = SEQ_WR1;
          end
        end else begin
          port_b_is_io_next = byte_q[3];
          port_b_fixed_next = byte_q[5:4];
          if ((byte_q & dma_seq_pkg::WR12_FOLLOW_BIT) != 8'd0) begin
            sequence_state_next = SEQ_WR2;
          end
        end
      end
      SEQ_WR0: begin
        priority if (wr0_pending[0]) begin
          port_a_start_next = {port_a_start[15:8], byte_q};
          wr0_pending_next  = wr0_pending & 4'b1110;
        end else if (wr0_pending[1]) begin
          port_a_start_next = {byte_q, port_a_start[7:0]};
          wr0_pending_next  = wr0_pending & 4'b1100;
        end else if (wr0_pending[2]) begin
          block_length_next = {block_length[15:8], byte_q};
          wr0_pending_next  = wr0_pending & 4'b1000;
        end else if (wr0_pending[3]) begin
          block_length_next = {byte_q, block_length[7:0]};
          wr0_pending_next  = 4'd0;
        end else begin
          wr0_pending_next  = 4'd0;
        end
        if (wr0_pending_next == 4'd0) begin
          sequence_state_next = SEQ_BASE;
        end
      end
      SEQ_WR1: begin
        port_a_timing_next  = byte_q;
        sequence_state_next = SEQ_BASE;
      end
      SEQ_WR2: begin
        port_b_timing_next  = byte_q;
        sequence_state_next = SEQ_BASE;
      end
      SEQ_WR4: begin
        priority if (wr4_pending[0]) begin
          port_b_start_next = {port_b_start[15:8], byte_q};
          wr4_pending_next  = wr4_pending & 3'b110;
        end else if (wr4_pending[1]) begin
          port_b_start_next = {byte_q, port_b_start[7:0]};
          wr4_pending_next  = wr4_pending & 3'b100;
        end else if (wr4_pending[2]) begin
          interrupt_control_next = byte_q;
          wr4_pending_next       = 3'd0;
        end else begin
          wr4_pending_next       = 3'd0;
        end
        if (wr4_pending_next == 3'd0) begin
          sequence_state_next = SEQ_BASE;
        end
      end
      default: begin
        sequence_state_next = SEQ_BASE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_state    <= SEQ_BASE;
      wr0_pending       <= 4'd0;
      wr4_pending       <= 3'd0;
      port_a_start      <= 16'd0;
      block_length      <= 16'd0;
      port_b_start      <= 16'd0;
      port_a_counter    <= 16'd0;
      port_b_counter    <= 16'd0;
      direction_flag    <= 1'b0;
      transfer_mode     <= 2'd0;
      port_a_is_io      <= 1'b0;
      port_a_fixed      <= 2'd0;
      port_b_is_io      <= 1'b0;
      port_b_fixed      <= 2'd0;
      port_a_timing     <= 8'd0;
      port_b_timing     <= 8'd0;
      interrupt_control <= 8'd0;
      wr5_value         <= 8'd0;
      enable_flag       <= 1'b0;
      force_ready_flag  <= 1'b0;
    end else if (proc_fire) begin
      sequence_state    <= sequence_state_next;
      wr0_pending       <= wr0_pending_next;
      wr4_pending       <= wr4_pending_next;
      port_a_start      <= port_a_start_next;
      block_length      <= block_length_next;
      port_b_start      <= port_b_start_next;
      port_a_counter    <= port_a_counter_next;
      port_b_counter    <= port_b_counter_next;
      direction_flag    <= direction_flag_next;
      transfer_mode     <= transfer_mode_next;
      port_a_is_io      <= port_a_is_io_next;
      port_a_fixed      <= port_a_fixed_next;
      port_b_is_io      <= port_b_is_io_next;
      port_b_fixed      <= port_b_fixed_next;
      port_a_timing     <= port_a_timing_next;
      port_b_timing     <= port_b_timing_next;
      interrupt_control <= interrupt_control_next;
      wr5_value         <= wr5_value_next;
      enable_flag       <= enable_flag_next;
      force_ready_flag  <= force_ready_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      transfer_kind    <= kind_next;
      source_address   <= src_next;
      dest_address     <= dst_next;
      transfer_length  <= len_next;
      error_code       <= err_next;
      dma_enabled      <= enable_flag_next;
      ready_forced     <= force_ready_flag_next;
      awaiting_operand <= (sequence_state_next != SEQ_BASE);
    end
  end

`include "dma_register_programming_sequencer_assert.svh"

  `DRPS_ASSERT(a_base_no_pending, (sequence_state != SEQ_BASE) || (wr0_pending == 4'd0 && wr4_pending == 3'd0), "pending operands left in base state")
  `DRPS_ASSERT(a_wr0_has_pending, (sequence_state != SEQ_WR0) || (wr0_pending != 4'd0), "WR0 operand state with empty mask")
  `DRPS_ASSERT(a_wr4_has_pending, (sequence_state != SEQ_WR4) || (wr4_pending != 3'd0), "WR4 operand state with empty mask")
  `DRPS_ASSERT(a_kind_clean, !out_valid || transfer_kind == dma_seq_pkg::KIND_NONE || (error_code == dma_seq_pkg::ERR_OK && dma_enabled && !awaiting_operand), "transfer reported with error or disabled")
  `DRPS_ASSERT_NEXT(a_counter_advance, proc_fire && kind_next == dma_seq_pkg::KIND_MEM_TO_MEM, port_a_counter == 16'($past(port_a_counter) + $past(block_length) + 16'd1), "port A counter did not advance by length plus one")

endmodule

/* test/tb.sv */
// Self-checking testbench for the DMA register programming sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 570;

  typedef enum logic [2:0] {ST_BASE, ST_WR0, ST_WR1, ST_WR2, ST_WR4} prog_state_e;

  typedef struct packed {
    dma_seq_pkg::kind_t kind;
    logic [15:0]        src;
    logic [15:0]        dst;
    logic [15:0]        len;
    dma_seq_pkg::err_t  err;
    logic               en;
    logic               rdy;
    logic               waiting;
  } dma_result_t;

  class dma_result_board;
    prog_state_e st;
    logic [3:0]  wr0_pend;
    logic [2:0]  wr4_pend;
    logic [15:0] a_start, blk_len, b_start, a_cnt, b_cnt;
    logic        dir, a_io, b_io, en, rdy;
    logic [1:0]  mode, a_fixed, b_fixed;
    logic [7:0]  a_tmg, b_tmg, intr_ctl, wr5;
    dma_result_t predicted_results[$];
    int          errors;

    function new();
      st = ST_BASE;
      wr0_pend = '0; wr4_pend = '0;
      a_start = '0; blk_len = '0; b_start = '0; a_cnt = '0; b_cnt = '0;
      dir = 1'b0; a_io = 1'b0; b_io = 1'b0; en = 1'b0; rdy = 1'b0;
      mode = '0; a_fixed = '0; b_fixed = '0;
      a_tmg = '0; b_tmg = '0; intr_ctl = '0; wr5 = '0;
      errors = 0;
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction

    function void note_byte(logic [7:0] d);
      dma_result_t r;
      r = '0;
      r.kind = dma_seq_pkg::KIND_NONE;
      r.err = dma_seq_pkg::ERR_OK;
      case (st)
        ST_BASE: begin
          if (d[7]) begin
            if (d[1:0] == dma_seq_pkg::SEL_WR4) begin
              wr4_pend = d[4:2];
              if (wr4_pend != 3'd0) st = ST_WR4;
            end else if (d[1:0] == dma_seq_pkg::SEL_WR5) begin
              wr5 = d;
            end else if (d[1:0] == dma_seq_pkg::SEL_WR6) begin
              case (d)
                dma_seq_pkg::CMD_DISABLE: en = 1'b0;
                dma_seq_pkg::CMD_ENABLE: begin
                  en = 1'b1;
                  if (rdy && dir && mode == dma_seq_pkg::MODE_TRANSFER && !a_io) begin
                    r.kind = dma_seq_pkg::KIND_MEM_TO_MEM;
                    r.src = a_cnt; r.dst = b_cnt; r.len = blk_len;
                    a_cnt = a_cnt + blk_len + 16'd1;
                    b_cnt = b_cnt + blk_len + 16'd1;
                  end else if (!rdy && !dir && mode == dma_seq_pkg::MODE_SEARCH && !a_io) begin
                    r.kind = dma_seq_pkg::KIND_SEARCH;
                    r.src = a_cnt; r.dst = b_cnt; r.len = blk_len;
                  end else begin
                    r.kind = dma_seq_pkg::KIND_UNSUPPORTED;
                  end
                end
                dma_seq_pkg::CMD_FORCE_READY: rdy = 1'b1;
                dma_seq_pkg::CMD_RESET: begin
                  en = 1'b0; rdy = 1'b0; a_tmg = '0; b_tmg = '0;
                end
                dma_seq_pkg::CMD_LOAD: begin
                  a_cnt = a_start; b_cnt = b_start; rdy = 1'b0;
                end
                default: r.err = dma_seq_pkg::ERR_BAD_WR6;
              endcase
            end else begin
              r.err = dma_seq_pkg::ERR_BAD_REG;
            end
          end else if (d[1:0] != 2'd0) begin
            dir = d[2];
            mode = d[1:0];
            wr0_pend = d[6:3];
            if (wr0_pend != 4'd0) st = ST_WR0;
          end else if (d[2]) begin
            a_io = d[3];
            a_fixed = d[5:4];
            if (d[6]) st = ST_WR1;
          end else begin
            b_io = d[3];
            b_fixed = d[5:4];
            if (d[6]) st = ST_WR2;
          end
        end
        ST_WR0: begin
          if (wr0_pend[0]) begin
            a_start[7:0] = d; wr0_pend[0] = 1'b0;
          end else if (wr0_pend[1]) begin
            a_start[15:8] = d; wr0_pend[1] = 1'b0;
          end else if (wr0_pend[2]) begin
            blk_len[7:0] = d; wr0_pend[2] = 1'b0;
          end else if (wr0_pend[3]) begin
            blk_len[15:8] = d; wr0_pend[3] = 1'b0;
          end
          if (wr0_pend == 4'd0) st = ST_BASE;
        end
        ST_WR1: begin
          a_tmg = d;
          st = ST_BASE;
        end
        ST_WR2: begin
          b_tmg = d;
          st = ST_BASE;
        end
        ST_WR4: begin
          if (wr4_pend[0]) begin
            b_start[7:0] = d; wr4_pend[0] = 1'b0;
          end else if (wr4_pend[1]) begin
            b_start[15:8] = d; wr4_pend[1] = 1'b0;
          end else if (wr4_pend[2]) begin
            intr_ctl = d; wr4_pend[2] = 1'b0;
          end
          if (wr4_pend == 3'd0) st = ST_BASE;
        end
        default: st = ST_BASE;
      endcase
      r.en = en;
      r.rdy = rdy;
      r.waiting = (st != ST_BASE);
      predicted_results.push_back(r);
    endfunction

    function void check_result(dma_result_t got);
      dma_result_t exp_r;
      if (predicted_results.size() == 0) begin
        $error("result transaction with no byte outstanding");
        errors++;
        return;
      end
      exp_r = predicted_results.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("transfer_kind: expected %0h, got %0h", exp_r.kind, got.kind);
        errors++;
      end
      if (got.src !== exp_r.src) begin
        $error("source_address: expected %0h, got %0h", exp_r.src, got.src);
        errors++;
      end
      if (got.dst !== exp_r.dst) begin
        $error("dest_address: expected %0h, got %0h", exp_r.dst, got.dst);
        errors++;
      end
      if (got.len !== exp_r.len) begin
        $error("transfer_length: expected %0h, got %0h", exp_r.len, got.len);
        errors++;
      end
      if (got.err !== exp_r.err) begin
        $error("error_code: expected %0h, got %0h", exp_r.err, got.err);
        errors++;
      end
      if (got.en !== exp_r.en) begin
        $error("dma_enabled: expected %0h, got %0h", exp_r.en, got.en);
        errors++;
      end
      if (got.rdy !== exp_r.rdy) begin
        $error("ready_forced: expected %0h, got %0h", exp_r.rdy, got.rdy);
        errors++;
      end
      if (got.waiting !== exp_r.waiting) begin
        $error("awaiting_operand: expected %0h, got %0h", exp_r.waiting, got.waiting);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  control_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  transfer_kind;
  logic [15:0] source_address;
  logic [15:0] dest_address;
  logic [15:0] transfer_length;
  logic [1:0]  error_code;
  logic        dma_enabled;
  logic        ready_forced;
  logic        awaiting_operand;

  dma_result_board board;
  dma_result_t     seen;
  int              send_idle_pct = 10;
  int              recv_idle_pct = 72;
  int              phase = 1;
  int              bytes_sent = 0;
  int              cycle_count = 0;
  logic            hold_off = 1'b0;

  dma_register_programming_sequencer DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .control_byte     (control_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .transfer_kind    (transfer_kind),
    .source_address   (source_address),
    .dest_address     (dest_address),
    .transfer_length  (transfer_length),
    .error_code       (error_code),
    .dma_enabled      (dma_enabled),
    .ready_forced     (ready_forced),
    .awaiting_operand (awaiting_operand)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_byte(control_byte);
      if (out_valid && !out_stall) begin
        seen.kind = transfer_kind;
        seen.src = source_address;
        seen.dst = dest_address;
        seen.len = transfer_length;
        seen.err = error_code;
        seen.en = dma_enabled;
        seen.rdy = ready_forced;
        seen.waiting = awaiting_operand;
        board.check_result(seen);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // hold the output for a long stretch so the block backs up into its input
  initial begin
    wait (phase == 3);
    repeat (20) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic write_control_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      control_byte <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    control_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_random_program();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (pick < 18) begin
      b[7] = 1'b0;
      case ($urandom_range(0, 2))
        0: {b[2], b[1:0]} = {1'b1, dma_seq_pkg::MODE_TRANSFER};
        1: {b[2], b[1:0]} = {1'b0, dma_seq_pkg::MODE_SEARCH};
        default: if (b[1:0] == 2'd0) b[0] = 1'b1;
      endcase
      write_control_byte(b);
      repeat ($countones(b[6:3])) write_control_byte(8'($urandom_range(0, 255)));
    end else if (pick < 28) begin
      b[7] = 1'b0;
      b[2:0] = 3'b100;
      if ($urandom_range(0, 3) != 0) b[3] = 1'b0;
      write_control_byte(b);
      if (b[6]) write_control_byte(8'($urandom_range(0, 255)));
    end else if (pick < 36) begin
      b[7] = 1'b0;
      b[2:0] = 3'b000;
      write_control_byte(b);
      if (b[6]) write_control_byte(8'($urandom_range(0, 255)));
    end else if (pick < 46) begin
      b[7] = 1'b1;
      b[1:0] = dma_seq_pkg::SEL_WR4;
      write_control_byte(b);
      repeat ($countones(b[4:2])) write_control_byte(8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      b[7] = 1'b1;
      b[1:0] = dma_seq_pkg::SEL_WR5;
      write_control_byte(b);
    end else if (pick < 82) begin
      case ($urandom_range(0, 6))
        0, 1: b = dma_seq_pkg::CMD_ENABLE;
        2, 3: b = dma_seq_pkg::CMD_FORCE_READY;
        4: b = dma_seq_pkg::CMD_LOAD;
        5: b = dma_seq_pkg::CMD_DISABLE;
        default: b = dma_seq_pkg::CMD_RESET;
      endcase
      write_control_byte(b);
    end else if (pick < 88) begin
      b[7] = 1'b1;
      b[1:0] = dma_seq_pkg::SEL_WR6;
      write_control_byte(b);
    end else if (pick < 92) begin
      b[7] = 1'b1;
      b[1:0] = 2'b00;
      write_control_byte(b);
    end else begin
      write_control_byte(b);
    end
  endtask

  task automatic drain_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed[$];
    board = new();
    // unsupported enable, bad WR6, bad register, bare WR2
    directed = {dma_seq_pkg::CMD_ENABLE, 8'hFF, 8'h80, 8'h00,
                // WR0: direction set, transfer mode, all four operands
                8'h7F, 8'h00, 8'h10, 8'hFF, 8'hFF,
                // WR4 with port B start and interrupt control
                8'h9D, 8'h00, 8'h20, 8'hFF,
                // WR1 and WR2 with timing bytes that look like commands
                8'h44, dma_seq_pkg::CMD_ENABLE, 8'h40, dma_seq_pkg::CMD_LOAD,
                8'h82, dma_seq_pkg::CMD_LOAD, dma_seq_pkg::CMD_FORCE_READY,
                dma_seq_pkg::CMD_ENABLE, dma_seq_pkg::CMD_DISABLE,
                dma_seq_pkg::CMD_RESET,
                // search mode setup, then enable
                8'h02, dma_seq_pkg::CMD_ENABLE};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) write_control_byte(directed[i]);
    while (bytes_sent < ITEMS_PER_PHASE) write_random_program();
    in_valid <= 1'b0;
    drain_results();
    send_idle_pct = 72;
    recv_idle_pct = 10;
    phase = 2;
    @(negedge clk);
    while (bytes_sent < 2 * ITEMS_PER_PHASE) write_random_program();
    in_valid <= 1'b0;
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase = 3;
    @(negedge clk);
    while (bytes_sent < 3 * ITEMS_PER_PHASE) write_random_program();
    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
